// ===== rtl/ray_box_slab_test_defines.svh =====
// Assertion macros for the ray / box slab test
`ifndef RAY_BOX_SLAB_TEST_DEFINES_SVH
`define RAY_BOX_SLAB_TEST_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define RBST_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication after a fixed number of cycles
`define RBST_ASSERT_DLY(lbl, ante, n, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##n (cons)) \
		else $error(msg);

`endif

// ===== rtl/rbst_pkg.sv =====
// Shared widths, register indexes and types for the ray / box slab test
package rbst_pkg;

	// coordinate, plane difference, reciprocal magnitude and t widths
	localparam int CW = 32;
	localparam int DFW = CW + 1;
	localparam int QW = 49;
	localparam int TW = 64;

	// reciprocal divider bits resolved per pipeline stage
	localparam int RBST_DIV_BITS = 4;

	// configuration register index
	localparam int CFG_IW = 3;

	typedef enum logic [CFG_IW-1:0] {
		REG_BOX_MIN_X = 3'd0,
		REG_BOX_MIN_Y = 3'd1,
		REG_BOX_MIN_Z = 3'd2,
		REG_BOX_MAX_X = 3'd3,
		REG_BOX_MAX_Y = 3'd4,
		REG_BOX_MAX_Z = 3'd5
	} cfg_reg_t;

	// ordered entry/exit distances of one slab
	typedef struct packed {
		logic signed [TW-1:0] lo;
		logic signed [TW-1:0] hi;
	} span_t;

endpackage

// ===== rtl/rbst_recip.sv =====
// Pipelined restoring divider: magnitude of 2^48 / |dir| with sign, plus a sideband
module rbst_recip import rbst_pkg::*; #(
	parameter int DIV_BITS = RBST_DIV_BITS,
	parameter int SIDE_W = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic signed [CW-1:0] in_dir,
	input  logic [SIDE_W-1:0]    in_side,
	output logic                 out_valid,
	output logic [QW-1:0]        out_mag,
	output logic                 out_neg,
	output logic [SIDE_W-1:0]    out_side
);

	localparam int NS = (QW + DIV_BITS - 1) / DIV_BITS;
	localparam int DW = NS * DIV_BITS;
	localparam logic [DW-1:0] DIVIDEND = {{(DW-1){1'b0}}, 1'b1} << (QW - 1);
	localparam logic [QW-1:0] RECIP_ZERO = {1'b1, {(QW-1){1'b0}}};

	logic              valid_s [NS+1];
	logic [CW-1:0]     rem_s   [NS+1];
	logic [DW-1:0]     quo_s   [NS+1];
	logic [CW-1:0]     mag_s   [NS+1];
	logic              neg_s   [NS+1];
	logic              zero_s  [NS+1];
	logic [SIDE_W-1:0] side_s  [NS+1];

	// take magnitude and sign of the direction at the pipe entry
	assign valid_s[0] = in_valid;
	assign rem_s[0]   = '0;
	assign quo_s[0]   = '0;
	assign mag_s[0]   = in_dir[CW-1] ? CW'(-in_dir) : CW'(in_dir);
	assign neg_s[0]   = in_dir[CW-1];
	assign zero_s[0]  = (in_dir == '0);
	assign side_s[0]  = in_side;

	for (genvar j = 0; j < NS; j++) begin : g_stage
		logic [CW-1:0] rem_nx;
		logic [DW-1:0] quo_nx;

		// resolve DIV_BITS quotient bits
		always_comb begin
			logic [CW:0] rr;
			rem_nx = rem_s[j];
			quo_nx = quo_s[j];
			for (int b = 0; b < DIV_BITS; b++) begin
				rr = {rem_nx, DIVIDEND[DW-1-j*DIV_BITS-b]};
				quo_nx = quo_nx << 1;
				if (rr >= {1'b0, mag_s[j]}) begin
					rr = rr - {1'b0, mag_s[j]};
					quo_nx[0] = 1'b1;
				end
				rem_nx = rr[CW-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[j+1] <= 1'b0;
			end else begin
				valid_s[j+1] <= valid_s[j];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[j+1]  <= rem_nx;
			quo_s[j+1]  <= quo_nx;
			mag_s[j+1]  <= mag_s[j];
			neg_s[j+1]  <= neg_s[j];
			zero_s[j+1] <= zero_s[j];
			side_s[j+1] <= side_s[j];
		end
	end

	// zero direction takes the largest reciprocal, positive
	assign out_valid = valid_s[NS];
	assign out_mag   = zero_s[NS] ? RECIP_ZERO : quo_s[NS][QW-1:0];
	assign out_neg   = neg_s[NS] && !zero_s[NS];
	assign out_side  = side_s[NS];

endmodule

// ===== rtl/rbst_slab.sv =====
// Slab distances of one axis: two products with the reciprocal, then ordered
module rbst_slab import rbst_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic signed [DFW-1:0] diff_a,
	input  logic signed [DFW-1:0] diff_b,
	input  logic [QW-1:0]         in_mag,
	input  logic                  in_neg,
	input  logic signed [CW-1:0]  in_dir,
	output logic                  out_valid,
	output span_t                 out_span,
	output logic signed [CW-1:0]  out_dir
);

	localparam int PW = CW + QW;
	localparam int HW = QW - CW;
	localparam logic [TW-2:0] T_SAT = '1;

	logic                 valid_s1, valid_s2, valid_s3;
	logic [2*CW-1:0]      plo_s1 [2];
	logic [CW+HW-1:0]     phi_s1 [2];
	logic                 sgn_s1 [2];
	logic signed [TW-1:0] t_s2   [2];
	logic signed [CW-1:0] dir_s1, dir_s2, dir_s3;
	span_t                span_s3;

	logic signed [DFW-1:0] diff [2];
	logic [CW-1:0]         dmag [2];
	logic signed [TW-1:0]  t_nx [2];

	assign diff[0] = diff_a;
	assign diff[1] = diff_b;

	// take the magnitude of each plane difference for the low and high partial products
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			dmag[i] = diff[i][DFW-1] ? CW'(-diff[i]) : CW'(diff[i]);
		end
	end

	// sum partials, shift to Q32.32, saturate and apply sign
	always_comb begin
		logic [PW-1:0]   p;
		logic [TW-2:0]   m;
		for (int i = 0; i < 2; i++) begin
			p = PW'(plo_s1[i]) + {phi_s1[i], {CW{1'b0}}};
			m = (p[PW-1:TW-1+16] != '0) ? T_SAT : p[TW-2+16:16];
			t_nx[i] = sgn_s1[i] ? -$signed({1'b0, m}) : $signed({1'b0, m});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 2; i++) begin
			plo_s1[i] <= dmag[i] * in_mag[CW-1:0];
			phi_s1[i] <= dmag[i] * in_mag[QW-1:CW];
			sgn_s1[i] <= diff[i][DFW-1] ^ in_neg;
			t_s2[i]   <= t_nx[i];
		end
		dir_s1 <= in_dir;
		dir_s2 <= dir_s1;
		dir_s3 <= dir_s2;
		// order the two plane distances
		if (t_s2[0] < t_s2[1]) begin
			span_s3.lo <= t_s2[0];
			span_s3.hi <= t_s2[1];
		end else begin
			span_s3.lo <= t_s2[1];
			span_s3.hi <= t_s2[0];
		end
	end

	assign out_valid = valid_s3;
	assign out_span  = span_s3;
	assign out_dir   = dir_s3;

endmodule

// ===== rtl/rbst_dist.sv =====
// Merge the three slabs, decide the hit and compute the squared entry distance
module rbst_dist import rbst_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  span_t                in_span [3],
	input  logic signed [CW-1:0] in_dir  [3],
	output logic                 out_valid,
	output logic                 out_hit,
	output logic [TW-1:0]        out_dist
);

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;
	logic signed [TW-1:0] tmin_s1, tmax_s1, tmin_s2, tmax_s2;
	span_t                z_s1;
	logic [CW-1:0]        md_s1 [3], md_s2 [3], md_s3 [3];
	logic                 hit_s3, hit_s4, hit_s5, hit_s6;
	logic [TW-1:0]        mt_s3;
	logic [TW-1:0]        pa_s4 [3], pb_s4 [3];
	logic [CW-1:0]        p_s5  [3];
	logic                 ovf_s5, ovf_s6;
	logic [TW-1:0]        sq_s6 [3];
	logic                 hit_s7;
	logic [TW-1:0]        dist_s7;

	logic [TW-1:0] p_nx [3];
	logic [TW+1:0] sum_nx;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			p_nx[k] = pa_s4[k] + (pb_s4[k] >> CW);
		end
		sum_nx = (TW+2)'(sq_s6[0]) + (TW+2)'(sq_s6[1]) + (TW+2)'(sq_s6[2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		// fold x and y slabs, hold z
		tmin_s1 <= (in_span[1].lo > in_span[0].lo) ? in_span[1].lo : in_span[0].lo;
		tmax_s1 <= (in_span[1].hi < in_span[0].hi) ? in_span[1].hi : in_span[0].hi;
		z_s1    <= in_span[2];
		for (int k = 0; k < 3; k++) begin
			md_s1[k] <= in_dir[k][CW-1] ? CW'(-in_dir[k]) : CW'(in_dir[k]);
			md_s2[k] <= md_s1[k];
			md_s3[k] <= md_s2[k];
		end

		// fold z slab
		tmin_s2 <= (z_s1.lo > tmin_s1) ? z_s1.lo : tmin_s1;
		tmax_s2 <= (z_s1.hi < tmax_s1) ? z_s1.hi : tmax_s1;

		// decide the hit, take |tmin|
		hit_s3 <= (tmin_s2 <= tmax_s2) && (tmax_s2 > 0);
		mt_s3  <= tmin_s2[TW-1] ? TW'(-tmin_s2) : TW'(tmin_s2);

		// entry component partial products
		hit_s4 <= hit_s3;
		for (int k = 0; k < 3; k++) begin
			pa_s4[k] <= mt_s3[TW-1:CW] * md_s3[k];
			pb_s4[k] <= mt_s3[CW-1:0] * md_s3[k];
		end

		// combine partials, flag a component past 32 bits
		hit_s5 <= hit_s4;
		ovf_s5 <= (p_nx[0][TW-1:CW] != '0) || (p_nx[1][TW-1:CW] != '0) ||
			(p_nx[2][TW-1:CW] != '0);
		for (int k = 0; k < 3; k++) begin
			p_s5[k] <= p_nx[k][CW-1:0];
		end

		// square each component
		hit_s6 <= hit_s5;
		ovf_s6 <= ovf_s5;
		for (int k = 0; k < 3; k++) begin
			sq_s6[k] <= p_s5[k] * p_s5[k];
		end

		// sum with saturation, zero on a miss
		hit_s7 <= hit_s6;
		if (!hit_s6) begin
			dist_s7 <= '0;
		end else if (ovf_s6 || (sum_nx[TW+1:TW] != '0)) begin
			dist_s7 <= '1;
		end else begin
			dist_s7 <= sum_nx[TW-1:0];
		end
	end

	assign out_valid = valid_s7;
	assign out_hit   = hit_s7;
	assign out_dist  = dist_s7;

endmodule

// ===== rtl/ray_box_slab_test.sv =====
// Ray / axis-aligned box slab test, one ray per cycle through a fixed-latency pipeline.
// Throughput: one ray accepted every clock cycle; busy stays low.
// A result travels from the accepting edge through the input register, the reciprocal divider
// pipe that resolves DIV_BITS quotient bits per stage, the slab stages and the distance stages.
// Reset: arst_n clears the box corners to zero and empties the pipeline; no clearing pass.
// The receiver cannot stall: every result is shown for exactly one cycle with done.
`include "ray_box_slab_test_defines.svh"

module ray_box_slab_test import rbst_pkg::*; #(
	parameter int DIV_BITS = RBST_DIV_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic signed [CW-1:0] origin_x,
	input  logic signed [CW-1:0] origin_y,
	input  logic signed [CW-1:0] origin_z,
	input  logic signed [CW-1:0] dir_x,
	input  logic signed [CW-1:0] dir_y,
	input  logic signed [CW-1:0] dir_z,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IW-1:0]    cfg_index,
	input  logic [CW-1:0]        cfg_data,
	output logic                 done,
	output logic                 hit,
	output logic [TW-1:0]        dist_sq
);

	localparam int NS = (QW + DIV_BITS - 1) / DIV_BITS;
	localparam int LAT = NS + 11;
	localparam int SW = 2 * DFW + CW;

	logic signed [CW-1:0] box_min_q [3];
	logic signed [CW-1:0] box_max_q [3];

	logic                 valid_s1;
	logic signed [CW-1:0] org_s1 [3];
	logic signed [CW-1:0] dir_s1 [3];

	logic                  div_valid [3];
	logic [QW-1:0]         div_mag   [3];
	logic                  div_neg   [3];
	logic [SW-1:0]         side_in   [3];
	logic [SW-1:0]         side_out  [3];
	logic                  slab_valid [3];
	span_t                 slab_span  [3];
	logic signed [CW-1:0]  slab_dir   [3];

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// write box corners; indexes past the last register are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				box_min_q[k] <= '0;
				box_max_q[k] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_BOX_MIN_X: box_min_q[0] <= cfg_data;
				REG_BOX_MIN_Y: box_min_q[1] <= cfg_data;
				REG_BOX_MIN_Z: box_min_q[2] <= cfg_data;
				REG_BOX_MAX_X: box_max_q[0] <= cfg_data;
				REG_BOX_MAX_Y: box_max_q[1] <= cfg_data;
				REG_BOX_MAX_Z: box_max_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// capture the ray on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		org_s1[0] <= origin_x;
		org_s1[1] <= origin_y;
		org_s1[2] <= origin_z;
		dir_s1[0] <= dir_x;
		dir_s1[1] <= dir_y;
		dir_s1[2] <= dir_z;
	end

	for (genvar k = 0; k < 3; k++) begin : g_axis
		logic signed [DFW-1:0] dlo, dhi;

		// exact plane minus origin, carried beside the divider
		assign dlo = DFW'(box_min_q[k]) - DFW'(org_s1[k]);
		assign dhi = DFW'(box_max_q[k]) - DFW'(org_s1[k]);
		assign side_in[k] = {dlo, dhi, dir_s1[k]};

		rbst_recip #(
			.DIV_BITS (DIV_BITS),
			.SIDE_W   (SW)
		) u_recip (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid_s1),
			.in_dir    (dir_s1[k]),
			.in_side   (side_in[k]),
			.out_valid (div_valid[k]),
			.out_mag   (div_mag[k]),
			.out_neg   (div_neg[k]),
			.out_side  (side_out[k])
		);

		rbst_slab u_slab (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (div_valid[k]),
			.diff_a    (side_out[k][SW-1:SW-DFW]),
			.diff_b    (side_out[k][CW+DFW-1:CW]),
			.in_mag    (div_mag[k]),
			.in_neg    (div_neg[k]),
			.in_dir    (side_out[k][CW-1:0]),
			.out_valid (slab_valid[k]),
			.out_span  (slab_span[k]),
			.out_dir   (slab_dir[k])
		);
	end

	rbst_dist u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (slab_valid[0]),
		.in_span   (slab_span),
		.in_dir    (slab_dir),
		.out_valid (done),
		.out_hit   (hit),
		.out_dist  (dist_sq)
	);

	// checks
	`RBST_ASSERT_DLY(a_latency, start && !busy, LAT, done, "result strobe missing after transfer")
	`RBST_ASSERT_IMP(a_miss_zero, done && !hit, dist_sq == '0, "miss reports nonzero distance")
	`RBST_ASSERT_IMP(a_axis_align, 1'b1,
		(div_valid[0] == div_valid[1]) && (div_valid[1] == div_valid[2]),
		"axis dividers out of step")

endmodule

// ===== tb/ray_box_slab_checker.sv =====
// Checker for the ray / box slab test: predicts each ray result and compares it
`timescale 1ns / 1ps

module ray_box_slab_checker import rbst_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  logic signed [CW-1:0] origin_x,
	input  logic signed [CW-1:0] origin_y,
	input  logic signed [CW-1:0] origin_z,
	input  logic signed [CW-1:0] dir_x,
	input  logic signed [CW-1:0] dir_y,
	input  logic signed [CW-1:0] dir_z,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IW-1:0]    cfg_index,
	input  logic [CW-1:0]        cfg_data,
	input  logic                 done,
	input  logic                 hit,
	input  logic [TW-1:0]        dist_sq,
	output int                   fail_count,
	output int                   pending,
	output int                   hit_count,
	output int                   ray_count
);

	typedef struct {
		logic        hit;
		logic [63:0] dist_sq;
	} hit_result_t;

	localparam logic [63:0] INV_UNIT = 64'd1 << 48;
	localparam logic [63:0] T_LIMIT  = 64'h7FFF_FFFF_FFFF_FFFF;

	logic signed [CW-1:0] box [6];
	hit_result_t          expected_hits [$];

	function automatic logic [63:0] mag(input logic signed [63:0] v);
		return v < 0 ? -v : v;
	endfunction

	// reciprocal of a Q16.16 direction in Q32.32, zero maps to the largest
	function automatic logic signed [63:0] dir_recip(input logic signed [63:0] d);
		logic [63:0] q;
		if (d == 0) return INV_UNIT;
		q = INV_UNIT / mag(d);
		return d < 0 ? -$signed(q) : $signed(q);
	endfunction

	// plane distance along the ray, Q32.32, saturating magnitude
	function automatic logic signed [63:0] plane_t(input logic signed [63:0] diff,
			input logic signed [63:0] inv);
		logic        neg;
		logic [63:0] md, mi, x, m;
		neg = (diff < 0) != (inv < 0);
		md = mag(diff);
		mi = mag(inv);
		x = md * mi[63:32];
		if (x >= (64'd1 << 47)) begin
			m = T_LIMIT;
		end else begin
			m = (x << 16) + ((md * {32'd0, mi[31:0]}) >> 16);
			if (m > T_LIMIT) m = T_LIMIT;
		end
		return neg ? -$signed(m) : $signed(m);
	endfunction

	function automatic hit_result_t trace_ray(input logic signed [CW-1:0] org [3],
			input logic signed [CW-1:0] dv [3]);
		hit_result_t       r;
		logic signed [63:0] tmin, tmax, inv, a, b, lo, hi;
		logic [63:0]       mt, md, p, sq, sum;
		logic              sat;
		tmin = 0;
		tmax = 0;
		for (int k = 0; k < 3; k++) begin
			inv = dir_recip(64'(dv[k]));
			a = plane_t(64'(box[k]) - 64'(org[k]), inv);
			b = plane_t(64'(box[3 + k]) - 64'(org[k]), inv);
			lo = a < b ? a : b;
			hi = a < b ? b : a;
			if (k == 0 || lo > tmin) tmin = lo;
			if (k == 0 || hi < tmax) tmax = hi;
		end
		r.hit = 0;
		r.dist_sq = 0;
		if (tmin <= tmax && tmax > 0) begin
			mt = mag(tmin);
			sum = 0;
			sat = 0;
			for (int k = 0; k < 3; k++) begin
				if (!sat) begin
					md = mag(64'(dv[k]));
					p = mt[63:32] * md + (({32'd0, mt[31:0]} * md) >> 32);
					if (p > 64'hFFFF_FFFF) begin
						sat = 1;
					end else begin
						sq = p * p;
						if (sum + sq < sum) sat = 1;
						else sum = sum + sq;
					end
				end
			end
			r.hit = 1;
			r.dist_sq = sat ? '1 : sum;
		end
		return r;
	endfunction

	// follow config writes, predict each ray transfer, compare each result
	always @(posedge clk or negedge arst_n) begin
		logic signed [CW-1:0] org [3];
		logic signed [CW-1:0] dv [3];
		hit_result_t          exp_r;
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) box[i] = 0;
			expected_hits.delete();
			fail_count = 0;
			hit_count = 0;
			ray_count = 0;
			pending = 0;
		end else begin
			if (done) begin
				if (expected_hits.size() == 0) begin
					$display("%0t: result with none expected: hit=%0b dist_sq=%h",
						$time, hit, dist_sq);
					fail_count++;
				end else begin
					exp_r = expected_hits.pop_front();
					if (hit !== exp_r.hit) begin
						$display("%0t: hit expected %0b actual %0b", $time, exp_r.hit, hit);
						fail_count++;
					end
					if (dist_sq !== exp_r.dist_sq) begin
						$display("%0t: dist_sq expected %h actual %h",
							$time, exp_r.dist_sq, dist_sq);
						fail_count++;
					end
					if (exp_r.hit) hit_count++;
				end
			end
			if (start && !busy) begin
				org = '{origin_x, origin_y, origin_z};
				dv = '{dir_x, dir_y, dir_z};
				expected_hits.push_back(trace_ray(org, dv));
				ray_count++;
			end
			if (cfg_valid && cfg_ready && cfg_index < 6) box[cfg_index] = cfg_data;
			pending = expected_hits.size();
		end
	end

endmodule

// ===== tb/tb_ray_box_slab_test.sv =====
// Testbench top for the ray / box slab test: stimulus, watchdog and verdict
`timescale 1ns / 1ps

module tb_ray_box_slab_test;
	import rbst_pkg::*;

	localparam int LATENCY = 40;
	localparam int WATCHDOG_LIMIT = 2000;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic signed [CW-1:0] origin_x, origin_y, origin_z, dir_x, dir_y, dir_z;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IW-1:0]    cfg_index;
	logic [CW-1:0]        cfg_data;
	logic                 done;
	logic                 hit;
	logic [TW-1:0]        dist_sq;
	int                   fail_count, pending, hit_count, ray_count;
	int                   idle_pct;
	int                   quiet_cycles;

	ray_box_slab_test u_dut (.*);

	ray_box_slab_checker u_checker (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// watchdog: count cycles with no transfer of any kind
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout after %0d quiet cycles", quiet_cycles);
			$display("FAIL ray_box_slab_test");
			$finish;
		end
	end

	function automatic logic [CW-1:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 4) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
			2: return 32'($signed($urandom_range(0, 40)) - 20);
			default: return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000);
		endcase
	endfunction

	// directions: half unit-scale, the rest tiny, zero, huge or raw
	function automatic logic [CW-1:0] rand_dir();
		case ($urandom_range(0, 7))
			0: return 0;
			1: return $urandom;
			2: return 32'($signed($urandom_range(0, 16)) - 8);
			3: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
			default: return 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000);
		endcase
	endfunction

	// present one register write; the caller drops cfg_valid after the last one
	task automatic write_reg(input cfg_reg_t idx, input logic [CW-1:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic set_box(input logic [CW-1:0] mnx, mny, mnz, mxx, mxy, mxz);
		write_reg(REG_BOX_MIN_X, mnx);
		write_reg(REG_BOX_MIN_Y, mny);
		write_reg(REG_BOX_MIN_Z, mnz);
		write_reg(REG_BOX_MAX_X, mxx);
		write_reg(REG_BOX_MAX_Y, mxy);
		write_reg(REG_BOX_MAX_Z, mxz);
		cfg_valid <= 0;
	endtask

	// hold start across back-to-back rays; drop it only while idling or draining
	task automatic send_ray(input logic [CW-1:0] ox, oy, oz, dx, dy, dz);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 0;
			@(negedge clk);
		end
		start <= 1;
		origin_x <= ox; origin_y <= oy; origin_z <= oz;
		dir_x <= dx; dir_y <= dy; dir_z <= dz;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	// wait for every result, then let the pipe drain before touching config
	task automatic drain();
		start <= 0;
		while (pending != 0) @(negedge clk);
		repeat (LATENCY) @(negedge clk);
	endtask

	task automatic random_box();
		logic [CW-1:0] c [6];
		for (int i = 0; i < 6; i++) c[i] = rand_coord();
		// keep most boxes ordered so hits are common
		if ($urandom_range(0, 4) != 0)
			for (int i = 0; i < 3; i++)
				if ($signed(c[i]) > $signed(c[3 + i])) {c[i], c[3 + i]} = {c[3 + i], c[i]};
		set_box(c[0], c[1], c[2], c[3], c[4], c[5]);
	endtask

	initial begin
		int idle_phase [4];
		idle_phase = '{0, 83, 0, 34};
		arst_n = 0;
		start = 0;
		cfg_valid = 0;
		cfg_index = 0;
		cfg_data = 0;
		idle_pct = 0;
		quiet_cycles = 0;
		{origin_x, origin_y, origin_z, dir_x, dir_y, dir_z} = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: reset box, then unit box around the origin
		send_ray(0, 0, 0, 32'h0001_0000, 0, 0);
		drain();
		set_box(32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000,
			32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
		send_ray(32'hFFFB_0000, 0, 0, 32'h0001_0000, 0, 0);
		send_ray(32'hFFFB_0000, 0, 0, 32'hFFFF_0000, 0, 0);
		send_ray(32'h0005_0000, 0, 0, 32'hFFFF_0000, 0, 0);
		send_ray(0, 0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
		send_ray(32'hFFFB_0000, 32'h0005_0000, 0, 32'h0001_0000, 0, 0);
		send_ray(32'hFFFB_0000, 32'hFFFB_0000, 32'hFFFB_0000, 1, 1, 1);
		send_ray(32'hFFFB_0000, 0, 0, 32'h7FFF_FFFF, 0, 0);
		send_ray(32'hFFFB_0000, 0, 0, 32'h8000_0000, 0, 0);
		send_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0);
		send_ray(32'h8000_0000, 0, 0, 1, 32'h8000_0000, 32'h7FFF_FFFF);
		drain();
		// extreme corners, then corners out of order
		set_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_ray(0, 0, 0, 1, 1, 1);
		send_ray(32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0);
		send_ray(0, 0, 0, 32'h0001_0000, 0, 0);
		drain();
		set_box(32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
			32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000);
		send_ray(32'hFFFB_0000, 0, 0, 32'h0001_0000, 0, 0);
		send_ray(0, 0, 0, 32'h0001_0000, 32'h0001_0000, 0);
		drain();
		// ignored index beyond the last register
		cfg_valid <= 1;
		cfg_index <= 3'd7;
		cfg_data <= $urandom;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 0;

		// random phases, a fresh box every batch
		for (int b = 0; b < 44; b++) begin
			idle_pct = idle_phase[(b / 11) % 4];
			drain();
			random_box();
			for (int i = 0; i < 25; i++)
				send_ray(rand_coord(), rand_coord(), rand_coord(),
					rand_dir(), rand_dir(), rand_dir());
		end

		drain();
		$display("covered %0d rays (%0d hits) over directed and random boxes",
			ray_count, hit_count);
		if (fail_count == 0) begin
			$display("PASS ray_box_slab_test");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("FAIL ray_box_slab_test");
		end
		$finish;
	end

endmodule

// ===== ray_box_slab_test.f =====
+incdir+rtl
rtl/rbst_pkg.sv
rtl/rbst_recip.sv
rtl/rbst_slab.sv
rtl/rbst_dist.sv
rtl/ray_box_slab_test.sv
tb/ray_box_slab_checker.sv
tb/tb_ray_box_slab_test.sv
